FILE: design/dfc_pkg.sv
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared types, constants and font tables of the digit frame composer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

  localparam int FrameRows         = 8;
  localparam int FrameCols         = 12;
  localparam int DefaultQueueDepth = 2;

  localparam int RowIdxW = $clog2(FrameRows);

  // Digit code that draws nothing
  localparam logic [3:0] DigitBlank = 4'hF;

  typedef enum logic [1:0] {
    MODE_TEMP = 2'd0,
    MODE_HUM  = 2'd1,
    MODE_TIME = 2'd2,
    MODE_DARK = 2'd3
  } mode_e;

  // One classified item as handed from the front to the back
  typedef struct packed {
    mode_e      mode;
    logic [3:0] dig0;
    logic [3:0] dig1;
    logic [3:0] dig2;
    logic [3:0] dig3;
    logic       dash;
    logic       dot;
  } desc_t;

  // Column c of a 3x5 digit; bit r is the r-th font row
  function automatic logic [4:0] font_col(input logic [3:0] d, input logic [1:0] c);
    logic [14:0] g;
    begin
      case (d)
        4'd0:    g = {5'h1F, 5'h11, 5'h1F};
        4'd1:    g = {5'h00, 5'h1F, 5'h00};
        4'd2:    g = {5'h17, 5'h15, 5'h1D};
        4'd3:    g = {5'h1F, 5'h15, 5'h15};
        4'd4:    g = {5'h1F, 5'h04, 5'h07};
        4'd5:    g = {5'h1D, 5'h15, 5'h17};
        4'd6:    g = {5'h1D, 5'h15, 5'h1F};
        4'd7:    g = {5'h1F, 5'h01, 5'h01};
        4'd8:    g = {5'h1F, 5'h15, 5'h1F};
        4'd9:    g = {5'h1F, 5'h15, 5'h17};
        default: g = '0;
      endcase
      case (c)
        2'd0:    font_col = g[4:0];
        2'd1:    font_col = g[9:5];
        2'd2:    font_col = g[14:10];
        default: font_col = '0;
      endcase
    end
  endfunction

  // Column c of the unit glyph: T for temperature, H for humidity
  function automatic logic [4:0] glyph_col(input mode_e m, input logic [1:0] c);
    logic [14:0] g;
    begin
      case (m)
        MODE_TEMP: g = {5'h01, 5'h1F, 5'h01};
        MODE_HUM:  g = {5'h1F, 5'h04, 5'h1F};
        default:   g = '0;
      endcase
      case (c)
        2'd0:    glyph_col = g[4:0];
        2'd1:    glyph_col = g[9:5];
        2'd2:    glyph_col = g[14:10];
        default: glyph_col = '0;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/digit_frame_composer_core.sv
// ----------------------------------------------------------------------------
// digit_frame_composer_core
// Composes a 12x8 dot-matrix frame (temperature, humidity or clock) per
// input beat and streams it out as eight 12-bit rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry mode, value and minutes.
//   A beat is taken on a clock edge with valid high and stall low.
//   Output channel: out_valid_o / out_stall_i carry row_index, row_pixels
//   and last; rows 0..7 of a frame come in order, last marks row 7.
//   Path: with the back end idle, the first row of a frame passes the
//   queue write, the descriptor load and the output register in turn.
//   Throughput: one output row per cycle while the receiver does not
//   stall; the row renderer in the back end is the bottleneck. Up to
//   QueueDepth items wait in the descriptor queue, so input is taken
//   while a frame is still streaming.
//   Receiver stall: the output register holds its row; the back end
//   stops, the queue fills, and then in_stall_o rises.
//   Reset: queue empty, no row pending, blink phase cleared so the first
//   clock frame lights the blink dot.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_frame_composer_core #(
  parameter int QueueDepth = dfc_pkg::DefaultQueueDepth
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic signed [9:0]                value_i,
  input  wire logic [6:0]                       minutes_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [dfc_pkg::RowIdxW-1:0]           row_index_o,
  output logic [dfc_pkg::FrameCols-1:0]         row_pixels_o,
  output logic                                  last_o
);
  import dfc_pkg::*;

  logic  q_full;
  logic  accept;
  desc_t front_desc;
  logic  head_valid;
  desc_t head_desc;
  logic  pop;

  // Stall the input only while the descriptor queue is full
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Front: split the reading into digits, advance the blink phase
  dfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .mode_i    (mode_i),
    .value_i   (value_i),
    .minutes_i (minutes_i),
    .desc_o    (front_desc)
  );

  // Decouple: hold classified items until the renderer is free
  dfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (accept),
    .push_desc_i  (front_desc),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc)
  );

  // Back: render rows 0..7 of each descriptor, one per beat
  dfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .row_pixels_o (row_pixels_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

FILE: design/dfc_front.sv
// ----------------------------------------------------------------------------
// dfc_front
// Classifies an accepted beat: splits readings into decimal digits and
// tracks the blink phase of the time display.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic signed [9:0]    value_i,
  input  wire logic [6:0]           minutes_i,
  output dfc_pkg::desc_t            desc_o
);
  import dfc_pkg::*;

  logic        blink_q, blink_d;
  mode_e       mode;
  logic        neg;
  logic [9:0]  mag;
  logic [17:0] vprod;
  logic [5:0]  vq;
  logic [9:0]  vr_full;
  logic [3:0]  vr;
  logic [14:0] mprod;
  logic [3:0]  mq;
  logic [6:0]  mr_full;
  logic [3:0]  mr;
  logic        in_range;

  assign mode = mode_e'(mode_i);
  assign neg  = value_i[9];
  assign mag  = neg ? (~value_i + 10'd1) : value_i;

  // Divide by ten: multiply by 205, drop 11 bits (exact below 1029)
  assign vprod   = {8'd0, mag} * 18'd205;
  assign vq      = vprod[16:11];
  assign vr_full = mag - 10'(vq) * 10'd10;
  assign vr      = vr_full[3:0];

  assign mprod   = {8'd0, minutes_i} * 15'd205;
  assign mq      = mprod[14:11];
  assign mr_full = minutes_i - 7'(mq) * 7'd10;
  assign mr      = mr_full[3:0];

  assign in_range = !neg && (mag <= 10'd99);

  always_comb begin
    desc_o      = '0;
    desc_o.mode = mode;
    desc_o.dig0 = DigitBlank;
    desc_o.dig1 = DigitBlank;
    desc_o.dig2 = DigitBlank;
    desc_o.dig3 = DigitBlank;
    case (mode)
      MODE_TEMP, MODE_HUM: begin
        if (in_range) begin
          // leading zero stays blank
          if (vq != 6'd0) desc_o.dig0 = vq[3:0];
          desc_o.dig1 = vr;
        end else begin
          desc_o.dash = 1'b1;
        end
      end
      MODE_TIME: begin
        // signed quotient/remainder truncate toward zero
        if (vq == 6'd0 || (!neg && vq <= 6'd9)) desc_o.dig0 = vq[3:0];
        if (!neg || vr == 4'd0) desc_o.dig1 = vr;
        if (mq <= 4'd9) desc_o.dig2 = mq;
        desc_o.dig3 = mr;
        desc_o.dot  = !blink_q;
      end
      default: ;
    endcase
  end

  assign blink_d = (accept_i && mode == MODE_TIME) ? !blink_q : blink_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q <= 1'b0;
    end else begin
      blink_q <= blink_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/dfc_queue.sv
// ----------------------------------------------------------------------------
// dfc_queue
// Short descriptor FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_queue #(
  parameter int Depth = dfc_pkg::DefaultQueueDepth
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire dfc_pkg::desc_t push_desc_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         head_valid_o,
  output dfc_pkg::desc_t head_desc_o
);
  import dfc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_desc_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_desc_i;
  end

endmodule

`default_nettype wire

FILE: design/dfc_back.sv
// ----------------------------------------------------------------------------
// dfc_back
// Renders one descriptor into eight frame rows, one row per beat, through
// an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            head_valid_i,
  input  wire dfc_pkg::desc_t                  head_desc_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [dfc_pkg::RowIdxW-1:0]          row_index_o,
  output logic [dfc_pkg::FrameCols-1:0]        row_pixels_o,
  output logic                                 last_o
);
  import dfc_pkg::*;

  localparam logic [RowIdxW-1:0] LastRow = RowIdxW'(FrameRows - 1);

  desc_t                desc_q;
  logic                 active_q, active_d;
  logic [RowIdxW-1:0]   row_q, row_d;
  logic                 ovalid_q, ovalid_d;
  logic [RowIdxW-1:0]   oidx_q;
  logic [FrameCols-1:0] opix_q;
  logic                 olast_q;

  logic                 adv, emit, load;
  logic [FrameCols-1:0] pix;
  logic [RowIdxW-1:0]   frow, grow;
  logic                 in_font, in_glyph;
  logic [3:0]           digs [4];
  logic [3:0]           left;
  logic [4:0]           fcol;
  logic [3:0]           x;

  assign adv  = !ovalid_q || !out_stall_i;
  assign emit = adv && active_q;
  assign load = adv && (!active_q || row_q == LastRow) && head_valid_i;
  assign pop_o = load;

  assign frow     = row_q - RowIdxW'(2);
  assign grow     = row_q - RowIdxW'(1);
  assign in_font  = (row_q >= RowIdxW'(2)) && (row_q <= RowIdxW'(6));
  assign in_glyph = (row_q >= RowIdxW'(1)) && (row_q <= RowIdxW'(5));

  assign digs[0] = desc_q.dig0;
  assign digs[1] = desc_q.dig1;
  assign digs[2] = desc_q.dig2;
  assign digs[3] = desc_q.dig3;

  // Pixels of the current row
  always_comb begin
    pix  = '0;
    left = '0;
    fcol = '0;
    x    = '0;
    for (int s = 0; s < 4; s++) begin
      if (desc_q.mode == MODE_TIME) left = 4'(3 * s);
      else left = (s == 0) ? 4'd1 : 4'd5;
      for (int c = 0; c < 3; c++) begin
        fcol = font_col(digs[s], 2'(c));
        x    = left + 4'(c);
        if (in_font && x < 4'(FrameCols) && fcol[frow]) pix[x] = 1'b1;
      end
    end
    for (int c = 0; c < 3; c++) begin
      fcol = glyph_col(desc_q.mode, 2'(c));
      if (in_glyph && fcol[grow]) pix[9 + c] = 1'b1;
    end
    if (desc_q.dash && row_q == RowIdxW'(3)) begin
      pix[1] = 1'b1;
      pix[2] = 1'b1;
      pix[5] = 1'b1;
      pix[6] = 1'b1;
    end
    if (desc_q.dot && row_q == LastRow) pix[6] = 1'b1;
  end

  always_comb begin
    active_d = active_q;
    row_d    = row_q;
    ovalid_d = ovalid_q;
    if (adv) ovalid_d = emit;
    if (emit) begin
      row_d = row_q + RowIdxW'(1);
      if (row_q == LastRow) active_d = 1'b0;
    end
    if (load) begin
      active_d = 1'b1;
      row_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) desc_q <= head_desc_i;
    if (emit) begin
      oidx_q  <= row_q;
      opix_q  <= pix;
      olast_q <= (row_q == LastRow);
    end
  end

  assign out_valid_o  = ovalid_q;
  assign row_index_o  = oidx_q;
  assign row_pixels_o = opix_q;
  assign last_o       = olast_q;

endmodule

`default_nettype wire

FILE: design/dfc_checker.sv
// ----------------------------------------------------------------------------
// dfc_checker
// Port-level checks of the frame composer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [dfc_pkg::RowIdxW-1:0]   row_index_o,
  input wire logic [dfc_pkg::FrameCols-1:0] row_pixels_o,
  input wire logic                          last_o
);
  import dfc_pkg::*;

  // Hold a stalled row
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_index_o)
      && $stable(row_pixels_o) && $stable(last_o))
    else $error("stalled output row changed");

  // Last flags exactly the bottom row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (row_index_o == RowIdxW'(FrameRows - 1))))
    else $error("last does not match the bottom row");

  // Rows of a frame advance by one
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      !out_valid_o || row_index_o == RowIdxW'($past(row_index_o) + 1'b1))
    else $error("row index skipped");

  // Nothing is ever drawn on the top row
  a_top_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_index_o == '0 |-> row_pixels_o == '0)
    else $error("top row lit");

endmodule

bind digit_frame_composer_core dfc_checker u_dfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .row_index_o  (row_index_o),
  .row_pixels_o (row_pixels_o),
  .last_o       (last_o)
);

`default_nettype wire
